### rtl/core/ssre_pkg.sv
// ----------------------------------------------------------------------------
// ssre_pkg
// Shared types, constants and the sine table builder of the stimulus core.
// ----------------------------------------------------------------------------
package ssre_pkg;

   localparam int unsigned StepIndexBits = 20;
   localparam int unsigned SampleBits    = 17;
   localparam int unsigned CsrIndexBits  = 3;
   localparam int unsigned CsrDataBits   = 32;
   localparam int unsigned CountBits     = 20;
   localparam int unsigned EnvFracBits   = 16;
   localparam int unsigned EnvBits       = EnvFracBits + 1;
   localparam int unsigned MagBits       = 15;
   localparam int unsigned SineBits      = MagBits + 1;
   localparam int unsigned MulBits       = 18;
   localparam int unsigned ProdBits      = 2 * MulBits;

   localparam logic [EnvBits-1:0] EnvOne    = EnvBits'(1) << EnvFracBits;
   localparam logic [MagBits-1:0] FullScale = 15'h7fff;

   localparam logic [63:0] OneQ30    = 64'd1 << 30;
   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

   typedef enum logic [CsrIndexBits-1:0] {
      REG_FREQUENCY_STEP  = 3'd0,
      REG_PHASE_OFFSET    = 3'd1,
      REG_AMPLITUDE       = 3'd2,
      REG_DC_LEVEL        = 3'd3,
      REG_TOTAL_STEPS     = 3'd4,
      REG_RAMP_UP_STEPS   = 3'd5,
      REG_RAMP_DOWN_STEPS = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [31:0]          frequency_step;
      logic [15:0]          phase_offset;
      logic [MagBits-1:0]   amplitude;
      logic [MagBits-1:0]   dc_level;
      logic [CountBits-1:0] total_steps;
      logic [CountBits-1:0] ramp_up_steps;
      logic [CountBits-1:0] ramp_down_steps;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [CountBits-1:0] dividend;
      logic [CountBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [EnvFracBits-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MUL_AMP,
      ST_SUM,
      ST_ENV,
      ST_MUL_ENV,
      ST_FIN
   } state_type;

   // quarter-wave entry, Q30 Taylor series in Horner form, rounded to unsigned Q0.15
   function automatic logic [MagBits-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned qtr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (HalfPiQ30 * 64'(idx)) >> qtr_bits;
      x2 = (x * x) >> 30;
      t  = OneQ30;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd156;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd110;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd72;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd42;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd20;
      t  = OneQ30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[MagBits-1:0];
   endfunction

endpackage

### rtl/core/ssre_if.sv
// ----------------------------------------------------------------------------
// ssre channel interfaces
// Valid/ready channels for tick requests, sample words and register writes.
// ----------------------------------------------------------------------------
interface ssre_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface ssre_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic [ssre_pkg::StepIndexBits-1:0]         step_index;
   logic signed [ssre_pkg::SampleBits-1:0]     sample_value;
   logic                                       session_last;
   logic                                       config_error;
   modport source (output valid, output step_index, output sample_value,
                   output session_last, output config_error, input ready);
   modport sink (input valid, input step_index, input sample_value,
                 input session_last, input config_error, output ready);
endinterface

interface ssre_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ssre_pkg::CsrIndexBits-1:0]   index;
   logic [ssre_pkg::CsrDataBits-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/ssre_csr.sv
// ----------------------------------------------------------------------------
// ssre_csr
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
module ssre_csr (
   input  logic              clock,
   input  logic              reset,
   ssre_csr_if.sink          csr_ch,
   output ssre_pkg::cfg_type cfg
);

   ssre_pkg::cfg_type cfg_ff;
   ssre_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (ssre_pkg::reg_index_type'(csr_ch.index))
            ssre_pkg::REG_FREQUENCY_STEP:  cfg_in.frequency_step  = csr_ch.data;
            ssre_pkg::REG_PHASE_OFFSET:    cfg_in.phase_offset    = csr_ch.data[15:0];
            ssre_pkg::REG_AMPLITUDE:       cfg_in.amplitude       = csr_ch.data[14:0];
            ssre_pkg::REG_DC_LEVEL:        cfg_in.dc_level        = csr_ch.data[14:0];
            ssre_pkg::REG_TOTAL_STEPS:     cfg_in.total_steps     = csr_ch.data[19:0];
            ssre_pkg::REG_RAMP_UP_STEPS:   cfg_in.ramp_up_steps   = csr_ch.data[19:0];
            ssre_pkg::REG_RAMP_DOWN_STEPS: cfg_in.ramp_down_steps = csr_ch.data[19:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{total_steps: ssre_pkg::CountBits'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/ssre_sine_rom.sv
// ----------------------------------------------------------------------------
// ssre_sine_rom
// Quarter-wave sine table with quadrant mirroring and registered signed output.
// ----------------------------------------------------------------------------
module ssre_sine_rom #(
   parameter int unsigned SINE_ADDR_BITS = 10
) (
   input  logic                                  clock,
   input  logic [SINE_ADDR_BITS-1:0]             addr,
   output logic signed [ssre_pkg::SineBits-1:0]  sine
);

   localparam int unsigned QtrBits = SINE_ADDR_BITS - 2;
   localparam int unsigned QtrSize = 1 << QtrBits;

   logic [ssre_pkg::MagBits-1:0]        sine_rom [QtrSize];
   logic [1:0]                          quad;
   logic [QtrBits-1:0]                  idx;
   logic [QtrBits-1:0]                  rd_idx;
   logic [ssre_pkg::MagBits-1:0]        mag;
   logic signed [ssre_pkg::SineBits-1:0] sine_in;
   logic signed [ssre_pkg::SineBits-1:0] sine_ff;

   for (genvar gi = 0; gi < QtrSize; gi++) begin : g_rom
      assign sine_rom[gi] = ssre_pkg::sine_entry(gi, QtrBits);
   end

   assign quad   = addr[SINE_ADDR_BITS-1 -: 2];
   assign idx    = addr[QtrBits-1:0];
   assign rd_idx = quad[0] ? (~idx + 1'b1) : idx;

   always_comb begin
      if (quad[0] && (idx == '0)) begin
         mag = ssre_pkg::FullScale;
      end else begin
         mag = sine_rom[rd_idx];
      end
      if (quad[1]) begin
         sine_in = -$signed({1'b0, mag});
      end else begin
         sine_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

### rtl/core/ssre_divider.sv
// ----------------------------------------------------------------------------
// ssre_divider
// Restoring divider, one quotient bit per cycle, for ramp envelope fractions.
// ----------------------------------------------------------------------------
module ssre_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  ssre_pkg::div_req_type req,
   output ssre_pkg::div_rsp_type rsp
);

   localparam int unsigned QBits   = ssre_pkg::EnvFracBits;
   localparam int unsigned CntBits = $clog2(QBits + 1);
   localparam int unsigned WBits   = ssre_pkg::CountBits;

   logic [WBits-1:0]   rem_ff;
   logic [WBits-1:0]   rem_in;
   logic [WBits-1:0]   den_ff;
   logic [QBits-1:0]   quot_ff;
   logic [QBits-1:0]   quot_in;
   logic [CntBits-1:0] cnt_ff;
   logic [CntBits-1:0] cnt_in;
   logic               busy_ff;
   logic               busy_in;
   logic               done_ff;
   logic               done_in;
   logic [WBits:0]     trial;
   logic               ge;

   assign trial = {rem_ff, 1'b0};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (req.start) begin
         rem_in  = req.dividend;
         quot_in = '0;
         cnt_in  = CntBits'(QBits);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? WBits'(trial - {1'b0, den_ff}) : trial[WBits-1:0];
         quot_in = {quot_ff[QBits-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (req.start) begin
         den_ff <= req.divisor;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

### rtl/core/sine_stimulus_with_ramp_envelope_core.sv
// ----------------------------------------------------------------------------
// sine_stimulus_with_ramp_envelope_core
// Phase-accumulator sine channel with amplitude, dc level and trapezoid envelope.
// ----------------------------------------------------------------------------
// Each request word is one tick and yields one sample word. The block takes a
// word only when its sequencer is idle; a finished sample may still wait in the
// output register. A tick on a ramp waits in the envelope state until the
// restoring divider that forms the ramp fraction is done; any other tick does
// not use the divider. Each tick goes through the table lookup and two passes
// through the one 18x18 multiplier. The next word can be taken in the cycle
// after the output register loads; a full output register that is not drained
// holds the sequencer in its last state.
// The sine table is a constant built at elaboration; there is no clearing pass.
module sine_stimulus_with_ramp_envelope_core #(
   parameter int unsigned SINE_ADDR_BITS = 10,
   parameter int unsigned STEP_BITS      = 20
) (
   input  logic        clock,
   input  logic        reset,
   ssre_req_if.sink    req_ch,
   ssre_rsp_if.source  rsp_ch,
   ssre_csr_if.sink    csr_ch
);

   localparam int unsigned NBits  = ((STEP_BITS > ssre_pkg::CountBits) ?
                                     STEP_BITS : ssre_pkg::CountBits) + 1;
   localparam int unsigned CBits  = ssre_pkg::CountBits;
   localparam int unsigned EBits  = ssre_pkg::EnvBits;
   localparam int unsigned MBits  = ssre_pkg::MulBits;
   localparam int unsigned PBits  = ssre_pkg::ProdBits;
   localparam int unsigned SBits  = ssre_pkg::SampleBits;
   localparam int unsigned XBits  = ssre_pkg::StepIndexBits;

   ssre_pkg::cfg_type     cfg;
   ssre_pkg::div_req_type div_req;
   ssre_pkg::div_rsp_type div_rsp;
   ssre_pkg::state_type   state_ff;
   ssre_pkg::state_type   state_in;

   logic [31:0]             acc_ff;
   logic [STEP_BITS-1:0]    cnt_ff;
   logic [31:0]             acc_cur;
   logic [STEP_BITS-1:0]    cnt_cur;
   logic [31:0]             phase;
   logic [SINE_ADDR_BITS-1:0] addr_ff;
   logic signed [ssre_pkg::SineBits-1:0] sine;

   logic [NBits-1:0]        n_ext;
   logic [NBits-1:0]        up_ext;
   logic [NBits-1:0]        dn_ext;
   logic [NBits-1:0]        tot_ext;
   logic                    below_up;
   logic                    flat;
   logic                    falling;
   logic                    err_cur;
   logic                    last_cur;

   logic                    accept;
   logic                    out_load;
   logic                    use_div_ff;
   logic [EBits-1:0]        env_const_ff;
   logic [EBits-1:0]        env_ff;
   logic [XBits-1:0]        idx_ff;
   logic                    last_ff;
   logic                    err_ff;

   logic signed [MBits-1:0] mul_a;
   logic signed [MBits-1:0] mul_b;
   logic signed [PBits-1:0] prod_in;
   logic signed [PBits-1:0] prod_ff;
   logic signed [SBits-1:0] sum_ff;
   logic signed [SBits-1:0] sum_in;

   logic                    rsp_valid_ff;
   logic [XBits-1:0]        rsp_idx_ff;
   logic signed [SBits-1:0] rsp_sample_ff;
   logic                    rsp_last_ff;
   logic                    rsp_err_ff;

   ssre_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ssre_sine_rom #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_rom (
      .clock (clock),
      .addr  (addr_ff),
      .sine  (sine)
   );

   ssre_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // tick front end
   assign acc_cur = req_ch.restart ? '0 : acc_ff;
   assign cnt_cur = req_ch.restart ? '0 : cnt_ff;
   assign phase   = acc_cur + {cfg.phase_offset, 16'h0000};

   assign n_ext    = NBits'(cnt_cur);
   assign up_ext   = NBits'(cfg.ramp_up_steps);
   assign dn_ext   = NBits'(cfg.ramp_down_steps);
   assign tot_ext  = NBits'(cfg.total_steps);
   assign below_up = n_ext < up_ext;
   assign flat     = (n_ext + dn_ext) <= tot_ext;
   assign falling  = (n_ext < tot_ext) && (cfg.ramp_down_steps != '0);
   assign err_cur  = ({1'b0, cfg.ramp_up_steps} + {1'b0, cfg.ramp_down_steps})
                     > {1'b0, cfg.total_steps};
   assign last_cur = (cfg.total_steps != '0) && (n_ext == (tot_ext - 1'b1));

   assign div_req.start    = accept && (below_up || (!flat && falling));
   assign div_req.dividend = below_up ? n_ext[CBits-1:0]
                                      : (cfg.total_steps - n_ext[CBits-1:0]);
   assign div_req.divisor  = below_up ? cfg.ramp_up_steps : cfg.ramp_down_steps;

   // shared multiplier
   always_comb begin
      if (state_ff == ssre_pkg::ST_MUL_AMP) begin
         mul_a = $signed(MBits'({1'b0, cfg.amplitude}));
         mul_b = MBits'(sine);
      end else begin
         mul_a = MBits'(sum_ff);
         mul_b = $signed(MBits'(env_ff));
      end
   end

   assign prod_in = mul_a * mul_b;
   assign sum_in  = SBits'($signed(prod_ff[30:15])) + $signed(SBits'({1'b0, cfg.dc_level}));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      accept        = 1'b0;
      out_load      = 1'b0;
      req_ch.ready  = 1'b0;
      unique case (state_ff)
         ssre_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               accept   = 1'b1;
               state_in = ssre_pkg::ST_LOOK;
            end
         end
         ssre_pkg::ST_LOOK:    state_in = ssre_pkg::ST_MUL_AMP;
         ssre_pkg::ST_MUL_AMP: state_in = ssre_pkg::ST_SUM;
         ssre_pkg::ST_SUM:     state_in = ssre_pkg::ST_ENV;
         ssre_pkg::ST_ENV: begin
            if (!use_div_ff || div_rsp.done) begin
               state_in = ssre_pkg::ST_MUL_ENV;
            end
         end
         ssre_pkg::ST_MUL_ENV: state_in = ssre_pkg::ST_FIN;
         ssre_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ssre_pkg::ST_IDLE;
            end
         end
         default: state_in = ssre_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssre_pkg::ST_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            acc_ff <= acc_cur + cfg.frequency_step;
            cnt_ff <= (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         addr_ff      <= phase[31 -: SINE_ADDR_BITS];
         idx_ff       <= n_ext[XBits-1:0];
         last_ff      <= last_cur;
         err_ff       <= err_cur;
         use_div_ff   <= div_req.start;
         env_const_ff <= (flat && !below_up) ? ssre_pkg::EnvOne : '0;
      end
      if (state_ff == ssre_pkg::ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ssre_pkg::ST_ENV) begin
         env_ff <= use_div_ff ? {1'b0, div_rsp.quotient} : env_const_ff;
      end
      if (out_load) begin
         rsp_idx_ff    <= idx_ff;
         rsp_sample_ff <= err_ff ? '0 : prod_ff[32:16];
         rsp_last_ff   <= last_ff;
         rsp_err_ff    <= err_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.step_index   = rsp_idx_ff;
   assign rsp_ch.sample_value = rsp_sample_ff;
   assign rsp_ch.session_last = rsp_last_ff;
   assign rsp_ch.config_error = rsp_err_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while sequencer busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_sample_ff == '0))
      else $error("config error word with nonzero sample");

   a_div_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssre_pkg::ST_MUL_ENV && use_div_ff) |-> $past(div_rsp.done))
      else $error("envelope used before divider finished");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssre_pkg::ST_MUL_ENV) |-> (env_ff <= ssre_pkg::EnvOne))
      else $error("envelope above one");

endmodule
